// File: hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared widths, codes, reset values and the queue entry type.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int ACTION_W     = 3;
    localparam int BYTE_W       = 8;
    localparam int UNIT_W       = 16;
    localparam int TIMEOUT_W    = 8;
    localparam int BIT_CNT_W    = 4;
    localparam int SUB_W        = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [UNIT_W-1:0]    UNIT_TICKS_RESET  = 16'd128;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [BIT_CNT_W-1:0] BYTE_BITS         = 4'd8;
    localparam logic [BYTE_W-1:0]    BYTE_MSB_MASK     = 8'h80;

    localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_WAIT  = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_UNIT_TICKS  = 1'b0,
        REG_ACK_TIMEOUT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ,
        CMD_WAIT
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [BYTE_W-1:0]  write_data;
        logic               send_ack;
        logic               sda_in;
    } cmd_item_t;

endpackage

// File: hw/rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// I2C master byte engine channels
// Request channel (one tick of the bus engine) and result channel.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [i2cm_pkg::ACTION_W-1:0]   action;
    logic [i2cm_pkg::BYTE_W-1:0]     write_data;
    logic                            send_ack;
    logic                            sda_in;

    modport source (output valid, output action, output write_data,
                    output send_ack, output sda_in, input ready);
    modport sink   (input valid, input action, input write_data,
                    input send_ack, input sda_in, output ready);
endinterface

interface i2cm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            scl_out;
    logic                            sda_out;
    logic                            sda_drive;
    logic                            busy_res;
    logic                            done_res;
    logic [i2cm_pkg::BYTE_W-1:0]     read_data;
    logic                            ack_failed;

    modport source (output valid, output scl_out, output sda_out,
                    output sda_drive, output busy_res, output done_res,
                    output read_data, output ack_failed, input ready);
    modport sink   (input valid, input scl_out, input sda_out,
                    input sda_drive, input busy_res, input done_res,
                    input read_data, input ack_failed, output ready);
endinterface

// File: hw/rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master: start, stop, write byte, read byte, wait for ack.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one request per engine tick: action, write_data, send_ack
//   and the sampled sda_in. Every request, including tick-only ones, yields
//   exactly one result on rsp with the bus levels and status after that tick.
//   A command action is taken only while the engine is idle; otherwise the
//   request just advances the current command.
//   A request accepted on cmd is decoded into a two-entry queue, stepped by
//   the engine and held in the result register, from which rsp offers it.
//   Throughput is one request per cycle while rsp is not stalled, set by the
//   single engine state update per cycle.
//   When rsp stalls, the result register holds and the queue fills; cmd.ready
//   drops once both queue entries are taken.
//   Reset: unit_ticks 128, ack_timeout_units 250, engine idle, SCL and SDA
//   released. cfg_we/cfg_index/cfg_data write a register on a clock edge;
//   write only while no request is in flight.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data,
    i2cm_cmd_if.sink                            cmd,
    i2cm_rsp_if.source                          rsp
);

    logic                  queue_full;
    logic                  push;
    i2cm_pkg::cmd_item_t   push_item;
    logic                  pop;
    logic                  pop_valid;
    i2cm_pkg::cmd_item_t   pop_item;

    i2cm_front u_front (
        .cmd        (cmd),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    i2cm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    i2cm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (pop_valid),
        .item       (pop_item),
        .item_pop   (pop),
        .rsp        (rsp)
    );

endmodule

// File: hw/rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts requests and decodes the action code into a command.
// ----------------------------------------------------------------------------
module i2cm_front (
    i2cm_cmd_if.sink              cmd,
    input  logic                  queue_full,
    output logic                  push,
    output i2cm_pkg::cmd_item_t   push_item
);

    i2cm_pkg::cmd_t cmd_dec;

    always_comb
    begin
        unique case (cmd.action)
            i2cm_pkg::ACT_START: cmd_dec = i2cm_pkg::CMD_START;
            i2cm_pkg::ACT_STOP:  cmd_dec = i2cm_pkg::CMD_STOP;
            i2cm_pkg::ACT_WRITE: cmd_dec = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::ACT_READ:  cmd_dec = i2cm_pkg::CMD_READ;
            i2cm_pkg::ACT_WAIT:  cmd_dec = i2cm_pkg::CMD_WAIT;
            default:             cmd_dec = i2cm_pkg::CMD_TICK;
        endcase
    end

    assign cmd.ready            = !queue_full;
    assign push                 = cmd.valid && !queue_full;
    assign push_item.cmd        = cmd_dec;
    assign push_item.write_data = cmd.write_data;
    assign push_item.send_ack   = cmd.send_ack;
    assign push_item.sda_in     = cmd.sda_in;

endmodule

// File: hw/rtl/i2cm_queue.sv
// ----------------------------------------------------------------------------
// I2C master request queue
// Short FIFO between the front end and the bus engine.
// ----------------------------------------------------------------------------
module i2cm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  i2cm_pkg::cmd_item_t   push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output i2cm_pkg::cmd_item_t   pop_item
);

    localparam int PTR_W = (i2cm_pkg::QUEUE_DEPTH > 1) ? $clog2(i2cm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(i2cm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(i2cm_pkg::QUEUE_DEPTH);

    i2cm_pkg::cmd_item_t entry_mem [i2cm_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_mem[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/i2cm_back.sv
// ----------------------------------------------------------------------------
// I2C master bus engine
// Steps the bit-level state machine once per tick and registers the result.
// ----------------------------------------------------------------------------
module i2cm_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_valid,
    input  i2cm_pkg::cmd_item_t                 item,
    output logic                                item_pop,
    i2cm_rsp_if.source                          rsp
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_STOP,
        PH_WRITE,
        PH_READ,
        PH_READ_ACK,
        PH_WAIT,
        PH_FAIL_STOP
    } phase_t;

    localparam int UW = i2cm_pkg::UNIT_W;
    localparam int TW = i2cm_pkg::TIMEOUT_W;
    localparam int BW = i2cm_pkg::BYTE_W;
    localparam int CW = i2cm_pkg::BIT_CNT_W;
    localparam int SW = i2cm_pkg::SUB_W;

    localparam logic [SW-1:0] SUB0 = SW'(0);
    localparam logic [SW-1:0] SUB1 = SW'(1);
    localparam logic [SW-1:0] SUB2 = SW'(2);
    localparam logic [SW-1:0] SUB3 = SW'(3);

    logic [UW-1:0] unit_ticks_reg;
    logic [TW-1:0] ack_timeout_reg;

    phase_t        phase_reg,    phase_next;
    logic [UW-1:0] unit_cnt_reg, unit_cnt_next;
    logic [SW-1:0] sub_reg,      sub_next;
    logic [CW-1:0] bit_cnt_reg,  bit_cnt_next;
    logic [BW-1:0] shift_reg,    shift_next;
    logic [TW-1:0] poll_reg,     poll_next;
    logic          scl_reg,      scl_next;
    logic          sda_reg,      sda_next;
    logic          drv_reg,      drv_next;
    logic          ackc_reg,     ackc_next;
    logic [BW-1:0] latch_reg,    latch_next;
    logic          done_next;
    logic          fail_next;

    logic          out_valid_reg;
    logic          scl_out_reg;
    logic          sda_out_reg;
    logic          sda_drive_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [BW-1:0] read_data_reg;
    logic          ack_failed_reg;

    logic [UW-1:0] unit_lim;
    logic [UW-1:0] cnt_inc;
    logic [CW-1:0] bit_inc;
    logic          fire;

    assign fire     = item_valid && (!out_valid_reg || rsp.ready);
    assign item_pop = fire;
    assign unit_lim = (unit_ticks_reg == '0) ? UW'(1) : unit_ticks_reg;
    assign cnt_inc  = unit_cnt_reg + 1'b1;
    assign bit_inc  = bit_cnt_reg + 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        unit_cnt_next = unit_cnt_reg;
        sub_next      = sub_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        poll_next     = poll_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        drv_next      = drv_reg;
        ackc_next     = ackc_reg;
        latch_next    = latch_reg;
        done_next     = 1'b0;
        fail_next     = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd != i2cm_pkg::CMD_TICK)
            begin
                unit_cnt_next = '0;
                sub_next      = SUB0;
                bit_cnt_next  = '0;
                poll_next     = '0;
            end
            unique case (item.cmd)
                i2cm_pkg::CMD_START:
                begin
                    phase_next = PH_START;
                    drv_next   = 1'b1;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                i2cm_pkg::CMD_STOP:
                begin
                    phase_next = PH_STOP;
                    drv_next   = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                end
                i2cm_pkg::CMD_WRITE:
                begin
                    phase_next = PH_WRITE;
                    drv_next   = 1'b1;
                    scl_next   = 1'b0;
                    shift_next = item.write_data;
                    sda_next   = |(item.write_data & i2cm_pkg::BYTE_MSB_MASK);
                end
                i2cm_pkg::CMD_READ:
                begin
                    phase_next = PH_READ;
                    drv_next   = 1'b0;
                    sda_next   = 1'b1;
                    scl_next   = 1'b0;
                    shift_next = '0;
                    ackc_next  = item.send_ack;
                end
                i2cm_pkg::CMD_WAIT:
                begin
                    phase_next = PH_WAIT;
                    drv_next   = 1'b0;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unit_cnt_next = cnt_inc;
            if (cnt_inc >= unit_lim)
            begin
                unit_cnt_next = '0;
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (sub_reg == SUB0)
                        begin
                            sda_next = 1'b0;
                            sub_next = SUB1;
                        end
                        else
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            sub_next   = SUB0;
                            done_next  = 1'b1;
                        end
                    end
                    PH_STOP:
                    begin
                        if (sub_reg == SUB0)
                        begin
                            scl_next = 1'b1;
                            sub_next = SUB1;
                        end
                        else
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_IDLE;
                            sub_next   = SUB0;
                            done_next  = 1'b1;
                        end
                    end
                    PH_FAIL_STOP:
                    begin
                        if (sub_reg == SUB0)
                        begin
                            scl_next = 1'b1;
                            sub_next = SUB1;
                        end
                        else
                        begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b0;
                            fail_next  = 1'b1;
                            phase_next = PH_IDLE;
                            sub_next   = SUB0;
                            done_next  = 1'b1;
                        end
                    end
                    PH_WAIT:
                    begin
                        if (sub_reg == SUB0)
                        begin
                            if (!item.sda_in)
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                sub_next   = SUB0;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                poll_next = '0;
                                sub_next  = SUB1;
                            end
                        end
                        else if (poll_reg >= ack_timeout_reg)
                        begin
                            drv_next   = 1'b1;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = PH_FAIL_STOP;
                            sub_next   = SUB0;
                        end
                        else if (!item.sda_in)
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            sub_next   = SUB0;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            poll_next = poll_reg + 1'b1;
                        end
                    end
                    PH_WRITE:
                    begin
                        case (sub_reg)
                            SUB0:
                            begin
                                scl_next = 1'b1;
                                sub_next = SUB1;
                            end
                            SUB1:
                            begin
                                sub_next = SUB2;
                            end
                            SUB2:
                            begin
                                scl_next = 1'b0;
                                sub_next = SUB3;
                            end
                            default:
                            begin
                                shift_next   = {shift_reg[BW-2:0], 1'b0};
                                bit_cnt_next = bit_inc;
                                if (bit_inc >= i2cm_pkg::BYTE_BITS)
                                begin
                                    phase_next = PH_IDLE;
                                    sub_next   = SUB0;
                                    done_next  = 1'b1;
                                end
                                else
                                begin
                                    sda_next = shift_reg[BW-2];
                                    sub_next = SUB0;
                                end
                            end
                        endcase
                    end
                    PH_READ:
                    begin
                        if (sub_reg == SUB0)
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[BW-2:0], item.sda_in};
                            sub_next   = SUB1;
                        end
                        else if (sub_reg == SUB1)
                        begin
                            sub_next = SUB2;
                        end
                        else
                        begin
                            bit_cnt_next = bit_inc;
                            scl_next     = 1'b0;
                            sub_next     = SUB0;
                            if (bit_inc >= i2cm_pkg::BYTE_BITS)
                            begin
                                phase_next = PH_READ_ACK;
                            end
                        end
                    end
                    PH_READ_ACK:
                    begin
                        if (sub_reg == SUB0)
                        begin
                            drv_next = 1'b1;
                            sda_next = !ackc_reg;
                            sub_next = SUB1;
                        end
                        else if (sub_reg == SUB1)
                        begin
                            scl_next = 1'b1;
                            sub_next = SUB2;
                        end
                        else
                        begin
                            scl_next   = 1'b0;
                            latch_next = shift_reg;
                            phase_next = PH_IDLE;
                            sub_next   = SUB0;
                            done_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        sub_next   = SUB0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg  <= i2cm_pkg::UNIT_TICKS_RESET;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RESET;
            phase_reg       <= PH_IDLE;
            unit_cnt_reg    <= '0;
            sub_reg         <= SUB0;
            bit_cnt_reg     <= '0;
            shift_reg       <= '0;
            poll_reg        <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            drv_reg         <= 1'b0;
            ackc_reg        <= 1'b0;
            latch_reg       <= '0;
            out_valid_reg   <= 1'b0;
            scl_out_reg     <= 1'b1;
            sda_out_reg     <= 1'b1;
            sda_drive_reg   <= 1'b0;
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            read_data_reg   <= '0;
            ack_failed_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    i2cm_pkg::REG_UNIT_TICKS:  unit_ticks_reg  <= cfg_data[UW-1:0];
                    i2cm_pkg::REG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[TW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (fire)
            begin
                phase_reg      <= phase_next;
                unit_cnt_reg   <= unit_cnt_next;
                sub_reg        <= sub_next;
                bit_cnt_reg    <= bit_cnt_next;
                shift_reg      <= shift_next;
                poll_reg       <= poll_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                drv_reg        <= drv_next;
                ackc_reg       <= ackc_next;
                latch_reg      <= latch_next;
                out_valid_reg  <= 1'b1;
                scl_out_reg    <= scl_next;
                sda_out_reg    <= drv_next ? sda_next : 1'b1;
                sda_drive_reg  <= drv_next;
                busy_reg       <= (phase_next != PH_IDLE);
                done_reg       <= done_next;
                read_data_reg  <= latch_next;
                ack_failed_reg <= done_next && fail_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.scl_out    = scl_out_reg;
    assign rsp.sda_out    = sda_out_reg;
    assign rsp.sda_drive  = sda_drive_reg;
    assign rsp.busy_res   = busy_reg;
    assign rsp.done_res   = done_reg;
    assign rsp.read_data  = read_data_reg;
    assign rsp.ack_failed = ack_failed_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> !busy_reg)
        else $error("done reported while still busy");

    a_fail_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        ack_failed_reg |-> done_reg)
        else $error("ack failure without done");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> unit_cnt_reg == '0 && sub_reg == SUB0)
        else $error("idle with unit count or step pending");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= i2cm_pkg::BYTE_BITS)
        else $error("bit count past one byte");

    a_last_step_write_only: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg == SUB3 |-> phase_reg == PH_WRITE)
        else $error("fourth step outside write byte");

endmodule
